FILE: hw/rtl/bfr_pkg.sv
// bfr_pkg: shared constants, field widths, mode codes and the extraction control
// struct for the bit field reader. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

   localparam int BUFFER_BYTES_DEF   = 256;
   localparam int MAX_FIELD_BITS_DEF = 32;

   localparam int MODE_W     = 3;
   localparam int BITCNT_W   = 6;
   localparam int VALUE_W    = 32;
   localparam int NUM_BANKS  = 8;
   localparam int BANK_SEL_W = 3;

   localparam int CNT_W_DEF = $clog2(BUFFER_BYTES_DEF + 1);
   localparam int POS_W_DEF = CNT_W_DEF + 3;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ALIGN = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

   typedef struct packed {
      logic                  ext;
      logic                  msb_first;
      logic [BANK_SEL_W-1:0] byte_off;
      logic [2:0]            bit_off;
      logic [BITCNT_W-1:0]   bit_count;
   } bfr_ctrl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bfr_req_if.sv
// bfr_req_if: request channel of the bit field reader (valid/ready plus request fields).
// Depends on bfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfr_req_if;
   import bfr_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [7:0]          data_byte;
   logic [BITCNT_W-1:0] bit_count;
   logic                msb_first;

   modport source (output valid, mode, data_byte, bit_count, msb_first, input ready);
   modport sink   (input valid, mode, data_byte, bit_count, msb_first, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bfr_rsp_if.sv
// bfr_rsp_if: response channel of the bit field reader (valid/ready plus result fields).
// Depends on bfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfr_rsp_if #(
   parameter int POS_W = bfr_pkg::POS_W_DEF,
   parameter int CNT_W = bfr_pkg::CNT_W_DEF
);
   import bfr_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               short_error;
   logic [POS_W-1:0]   bit_position;
   logic [CNT_W-1:0]   byte_position;

   modport source (output valid, value, short_error, bit_position, byte_position,
                   input ready);
   modport sink   (input valid, value, short_error, bit_position, byte_position,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bfr_byte_banks.sv
// bfr_byte_banks: byte buffer split into eight banks by byte address, one write port
// and a registered read of eight consecutive bytes. Depends on bfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfr_byte_banks #(
   parameter int BUFFER_BYTES = bfr_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
   input  wire logic [7:0]                      wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
   output logic      [7:0]                      rd_data [bfr_pkg::NUM_BANKS]
);
   import bfr_pkg::*;

   localparam int BANK_DEPTH = (BUFFER_BYTES + NUM_BANKS - 1) / NUM_BANKS;
   localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [7:0]       mem [BANK_DEPTH];
      logic [ROW_W-1:0] wr_row;
      logic [ROW_W-1:0] rd_row;
      logic [7:0]       rd_q;

      assign wr_row = ROW_W'(wr_addr >> BANK_SEL_W);
      // banks below the start bank hold bytes of the next row
      assign rd_row = ROW_W'(rd_addr >> BANK_SEL_W)
                    + ((BANK_SEL_W'(b) < rd_addr[BANK_SEL_W-1:0]) ? ROW_W'(1) : ROW_W'(0));

      always_ff @(posedge clock) begin
         if (wr_en && (wr_addr[BANK_SEL_W-1:0] == BANK_SEL_W'(b))) begin
            mem[wr_row] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_q <= mem[rd_row];
         end
      end

      assign rd_data[b] = rd_q;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bfr_extract.sv
// bfr_extract: lines up the bank bytes into a stream window and pulls out the
// requested field lsb-first or msb-first. Depends on bfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfr_extract #(
   parameter int MAX_FIELD_BITS = bfr_pkg::MAX_FIELD_BITS_DEF
) (
   input  wire logic [7:0]                   bank_data [bfr_pkg::NUM_BANKS],
   input  wire bfr_pkg::bfr_ctrl_type        ctrl,
   output logic      [bfr_pkg::VALUE_W-1:0]  value
);
   import bfr_pkg::*;

   // a field may start anywhere in its first byte
   localparam int WIN_BYTES = (MAX_FIELD_BITS + 14) / 8;
   localparam int WIN_W     = WIN_BYTES * 8;

   logic [WIN_W-1:0]   lsb_win;
   logic [WIN_W-1:0]   msb_win;
   logic [WIN_W-1:0]   lsb_sh;
   logic [WIN_W-1:0]   msb_sh;
   logic [VALUE_W:0]   mask;
   logic [VALUE_W-1:0] lsb_val;
   logic [VALUE_W-1:0] msb_val;

   always_comb begin
      for (int k = 0; k < WIN_BYTES; k++) begin
         lsb_win[8*k +: 8]             = bank_data[BANK_SEL_W'(ctrl.byte_off + BANK_SEL_W'(k))];
         msb_win[WIN_W-8-8*k +: 8]     = bank_data[BANK_SEL_W'(ctrl.byte_off + BANK_SEL_W'(k))];
      end
   end

   assign lsb_sh  = lsb_win >> ctrl.bit_off;
   assign mask    = ((VALUE_W+1)'(1) << ctrl.bit_count) - (VALUE_W+1)'(1);
   assign lsb_val = VALUE_W'(lsb_sh) & mask[VALUE_W-1:0];

   // first stream bit sits at the top of the window after the shift
   assign msb_sh  = msb_win << ctrl.bit_off;
   assign msb_val = VALUE_W'(msb_sh >> (WIN_W - int'(ctrl.bit_count)));

   assign value = !ctrl.ext ? '0 : (ctrl.msb_first ? msb_val : lsb_val);

endmodule

`default_nettype wire

FILE: hw/rtl/bit_field_reader.sv
// bit_field_reader: top level of the bit reader over a banked byte buffer.
// Depends on bfr_pkg, bfr_req_if, bfr_rsp_if, bfr_byte_banks and bfr_extract.
//
// Usage:
//   req channel: one request per transfer; mode selects load byte, peek bits,
//   read bits, align to byte or clear. Every request gives exactly one response.
//   rsp channel: extracted value (zero on error), short_error, the bit position
//   after the request and the byte count consumed, rounded up.
// Path: each request passes the read stage, then the output register.
// Throughput: one request per cycle unless stalled. Position and fill count update
//   at the request transfer from the request fields and the state registers alone,
//   and the buffer is banked eight ways so the five bytes a field can touch come
//   out of one registered read; the next request sees the new position at once.
// Reset: synchronous; buffer is emptied and the position rewinds to zero. Buffer
//   contents are not cleared, only the fill count, so no bytes are ever read
//   that were not loaded.
// Stall: with rsp_chan.ready low the output register holds its response, the
//   read stage fills, and then req_chan.ready drops until the response is taken.
`timescale 1ns / 1ps
`default_nettype none

module bit_field_reader #(
   parameter int BUFFER_BYTES   = bfr_pkg::BUFFER_BYTES_DEF,
   parameter int MAX_FIELD_BITS = bfr_pkg::MAX_FIELD_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bfr_req_if.sink    req_chan,
   bfr_rsp_if.source  rsp_chan
);
   import bfr_pkg::*;

   localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W  = CNT_W + 3;
   localparam int ADDR_W = $clog2(BUFFER_BYTES);

   // state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   // read stage
   logic             s1_valid_ff, s1_valid_in;
   bfr_ctrl_type     s1_ctrl_ff, s1_ctrl_in;
   logic             s1_err_ff;
   logic [POS_W-1:0] s1_pos_ff;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_err_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic [CNT_W-1:0]   out_bpos_ff;

   logic               accept;
   logic               out_free;
   logic               s1_move;
   logic               is_fetch;
   logic [POS_W-1:0]   avail;
   logic [POS_W-1:0]   remain;
   logic               req_err;
   logic               req_ext;
   logic               wr_en;
   logic [7:0]         bank_data [NUM_BANKS];
   logic [VALUE_W-1:0] ext_value;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_fetch = (req_chan.mode == MODE_PEEK) || (req_chan.mode == MODE_READ);
   assign avail    = {count_ff, 3'b000};
   assign remain   = avail - pos_ff;
   assign req_err  = is_fetch && (req_chan.bit_count != '0)
                   && ((req_chan.bit_count > BITCNT_W'(MAX_FIELD_BITS))
                       || (pos_ff > avail)
                       || (POS_W'(req_chan.bit_count) > remain));
   assign req_ext  = is_fetch && (req_chan.bit_count != '0) && !req_err;
   assign wr_en    = accept && (req_chan.mode == MODE_LOAD)
                   && (count_ff < CNT_W'(BUFFER_BYTES));

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      unique case (req_chan.mode)
         MODE_LOAD: begin
            if (count_ff < CNT_W'(BUFFER_BYTES)) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_PEEK: begin
         end
         MODE_READ: begin
            if (req_ext) begin
               pos_in = pos_ff + POS_W'(req_chan.bit_count);
            end
         end
         MODE_ALIGN: begin
            pos_in = (pos_ff + POS_W'(7)) & ~POS_W'(7);
         end
         MODE_CLEAR: begin
            count_in = '0;
            pos_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      s1_ctrl_in.ext       = req_ext;
      s1_ctrl_in.msb_first = req_chan.msb_first;
      s1_ctrl_in.byte_off  = pos_ff[3 +: BANK_SEL_W];
      s1_ctrl_in.bit_off   = pos_ff[2:0];
      s1_ctrl_in.bit_count = req_chan.bit_count;
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            count_ff <= count_in;
            pos_ff   <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_err_ff  <= req_err;
         s1_pos_ff  <= pos_in;
      end
      if (s1_move) begin
         out_value_ff <= ext_value;
         out_err_ff   <= s1_err_ff;
         out_pos_ff   <= s1_pos_ff;
         out_bpos_ff  <= CNT_W'((s1_pos_ff + POS_W'(7)) >> 3);
      end
   end

   bfr_byte_banks #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_banks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(count_ff)),
      .wr_data (req_chan.data_byte),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(pos_ff >> 3)),
      .rd_data (bank_data)
   );

   bfr_extract #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_extract (
      .bank_data (bank_data),
      .ctrl      (s1_ctrl_ff),
      .value     (ext_value)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.value         = out_value_ff;
   assign rsp_chan.short_error   = out_err_ff;
   assign rsp_chan.bit_position  = out_pos_ff;
   assign rsp_chan.byte_position = out_bpos_ff;

endmodule

`default_nettype wire
